FILE: src/sbp_pkg.sv
// Package: shared types and constants for the six-button pad port.
`timescale 1ns / 1ps

package sbp_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam int unsigned TIMEOUT_W     = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1600;
    localparam logic [2:0]  PHASE_WRAP    = 3'd5;
    localparam logic [2:0]  PHASE_EXTRA   = 3'd3;
    localparam logic [2:0]  PHASE_BLANK   = 3'd2;

    localparam int unsigned BTN_UP    = 0;
    localparam int unsigned BTN_DOWN  = 1;
    localparam int unsigned BTN_LEFT  = 2;
    localparam int unsigned BTN_RIGHT = 3;
    localparam int unsigned BTN_A     = 4;
    localparam int unsigned BTN_B     = 5;
    localparam int unsigned BTN_C     = 6;
    localparam int unsigned BTN_X     = 7;
    localparam int unsigned BTN_Y     = 8;
    localparam int unsigned BTN_Z     = 9;
    localparam int unsigned BTN_MODE  = 10;
    localparam int unsigned BTN_START = 11;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  write_data;
        logic [11:0] buttons;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

endpackage

FILE: src/sbp_if.sv
// Interfaces: input item channel and result channel of the pad port.
`timescale 1ns / 1ps

interface sbp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  write_data;
    logic [11:0] buttons;

    modport source (output valid, output mode, output write_data, output buttons,
                    input ready);
    modport sink (input valid, input mode, input write_data, input buttons,
                  output ready);
endinterface

interface sbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

FILE: src/sbp_in_reg.sv
// Input register: holds one accepted item until the core takes it.
`timescale 1ns / 1ps

module sbp_in_reg
    import sbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_item  i_item,
    input  logic   i_take,
    output t_stage o_stage
);

    logic  r_valid;
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

FILE: src/sbp_core.sv
// Core: pad state, direction latches and read data selection.
`timescale 1ns / 1ps

module sbp_core
    import sbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [TIMEOUT_W-1:0] i_cfg_wdata,
    input  t_stage               i_stage,
    input  logic                 i_take,
    output logic [7:0]           o_read_data
);

    logic [TIMEOUT_W-1:0] r_reload;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [2:0]           r_phase;
    logic                 r_select;
    logic                 r_latch;
    logic                 r_vhold;
    logic                 r_hhold;
    logic [3:0]           r_dir;

    logic [TIMEOUT_W-1:0] n_timeout;
    logic [2:0]           n_phase;
    logic                 n_select;
    logic                 n_latch;
    logic                 n_vhold;
    logic                 n_hhold;
    logic [3:0]           n_dir;
    logic [2:0]           w_phase_inc;
    logic [11:0]          w_btn;
    logic [5:0]           w_group;
    logic                 w_sel_in;

    assign w_btn       = i_stage.item.buttons;
    assign w_sel_in    = i_stage.item.write_data[6];
    assign w_phase_inc = r_phase + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_reload <= i_cfg_wdata;
        end
    end

    // direction latches: swap once while opposite directions are both held
    always_comb begin
        n_vhold = r_vhold;
        n_hhold = r_hhold;
        n_dir   = r_dir;
        if (!(w_btn[BTN_UP] && w_btn[BTN_DOWN])) begin
            n_vhold    = 1'b0;
            n_dir[1:0] = {w_btn[BTN_DOWN], w_btn[BTN_UP]};
        end else if (!r_vhold) begin
            n_vhold    = 1'b1;
            n_dir[1:0] = {r_dir[0], r_dir[1]};
        end
        if (!(w_btn[BTN_LEFT] && w_btn[BTN_RIGHT])) begin
            n_hhold    = 1'b0;
            n_dir[3:2] = {w_btn[BTN_RIGHT], w_btn[BTN_LEFT]};
        end else if (!r_hhold) begin
            n_hhold    = 1'b1;
            n_dir[3:2] = {r_dir[2], r_dir[3]};
        end
    end

    always_comb begin
        n_timeout = r_timeout;
        n_phase   = r_phase;
        n_select  = r_select;
        n_latch   = r_latch;
        case (i_stage.item.mode)
            MODE_WRITE: begin
                if (!r_select && w_sel_in) begin
                    n_phase = (w_phase_inc == PHASE_WRAP) ? 3'd0 : w_phase_inc;
                end
                n_select  = w_sel_in;
                n_latch   = i_stage.item.write_data[7];
                n_timeout = r_reload;
            end
            MODE_TICK: begin
                if (r_timeout != '0) begin
                    n_timeout = r_timeout - 1'b1;
                end else begin
                    n_phase = 3'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
            r_phase   <= '0;
            r_select  <= 1'b0;
            r_latch   <= 1'b0;
            r_vhold   <= 1'b0;
            r_hhold   <= 1'b0;
            r_dir     <= '0;
        end else if (i_take) begin
            r_timeout <= n_timeout;
            r_phase   <= n_phase;
            r_select  <= n_select;
            r_latch   <= n_latch;
            if (i_stage.item.mode == MODE_READ) begin
                r_vhold <= n_vhold;
                r_hhold <= n_hhold;
                r_dir   <= n_dir;
            end
        end
    end

    always_comb begin
        w_group = '0;
        if (!r_select) begin
            case (r_phase)
                3'd0, 3'd1, 3'd4: w_group[3:0] = {2'b11, n_dir[1:0]};
                PHASE_BLANK:      w_group[3:0] = 4'b1111;
                default:          w_group[3:0] = 4'b0000;
            endcase
            w_group[4] = w_btn[BTN_A];
            w_group[5] = w_btn[BTN_START];
        end else begin
            case (r_phase)
                3'd0, 3'd1, 3'd2, 3'd4: begin
                    w_group = {w_btn[BTN_C], w_btn[BTN_B], n_dir};
                end
                PHASE_EXTRA: begin
                    w_group = {2'b00, w_btn[BTN_MODE], w_btn[BTN_X], w_btn[BTN_Y],
                               w_btn[BTN_Z]};
                end
                default: w_group = '0;
            endcase
        end
    end

    assign o_read_data = {r_latch, r_select, ~w_group};

endmodule

FILE: src/sbp_out_reg.sv
// Output register: holds one result item until the receiver takes it.
`timescale 1ns / 1ps

module sbp_out_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_data,
    output logic       o_free,
    sbp_out_if.source  o_out
);

    logic       r_valid;
    logic [7:0] r_data;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.read_data = r_data;

endmodule

FILE: src/six_button_pad_port.sv
// Top level: six-button pad port with input register, core and output register.
//
// Usage:
//   i_pad carries one item per valid/ready handshake: a port read, a port
//   write (select in bit 6, latch in bit 7) or a one-microsecond tick.
//   o_pad carries one read_data result for every read; writes and ticks
//   give no result.
//   i_cfg_we / i_cfg_wdata load the timeout reload value; write it only
//   while no item is in flight.
// Path: a read is held in the input register, then its result is registered
//   in the output register once that register is free.
// Throughput: one item per cycle while no read waits on a held result, set
//   by the single register-to-register pass through the core.
// Reset: control state clears, the reload value returns to 1600, both
//   registers empty; their held item and data are not cleared.
// Stall: while o_pad.ready is low a held result blocks only the next read
//   in the input register; writes and ticks keep flowing, and i_pad.ready
//   drops once a read waits in the input register.
`timescale 1ns / 1ps

module six_button_pad_port
    import sbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [TIMEOUT_W-1:0] i_cfg_wdata,
    sbp_in_if.sink               i_pad,
    sbp_out_if.source            o_pad
);

    t_stage w_stage;
    t_item  w_item;
    logic   w_take;
    logic   w_load;
    logic   w_is_read;
    logic   w_out_free;
    logic [7:0] w_read_data;

    assign w_item.mode       = i_pad.mode;
    assign w_item.write_data = i_pad.write_data;
    assign w_item.buttons    = i_pad.buttons;

    assign w_is_read   = w_stage.item.mode == MODE_READ;
    assign w_take      = w_stage.valid && (!w_is_read || w_out_free);
    assign i_pad.ready = !w_stage.valid || w_take;
    assign w_load      = i_pad.valid && i_pad.ready;

    sbp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_item  (w_item),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    sbp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (w_stage),
        .i_take      (w_take),
        .o_read_data (w_read_data)
    );

    sbp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take && w_is_read),
        .i_data  (w_read_data),
        .o_free  (w_out_free),
        .o_out   (o_pad)
    );

`ifndef ASSERT_OFF
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage.valid && w_is_read && w_out_free) |=> o_pad.valid)
        else $error("read item did not produce a result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(w_stage.valid && w_is_read) && o_pad.valid && o_pad.ready) |=> !o_pad.valid)
        else $error("result appeared without a read item");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_stage.valid |-> i_pad.ready)
        else $error("input stalled with an empty input register");
`endif

endmodule
